// ===== hdl/ple_pkg.sv =====
package ple_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

endpackage

// ===== hdl/ple_ctrl.sv =====
module ple_ctrl
    import ple_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("load did not move controller to exec");

    a_valid_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_cmd.exec))
        else $error("result valid without exec");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec && o_valid) |-> i_ready)
        else $error("exec while result still pending");
`endif

endmodule

// ===== hdl/ple_dp.sv =====
module ple_dp
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd_ctl,
    input  logic                i_cmd,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]    i_position,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic                r_cmd;
    logic [VALUE_W-1:0]  r_value;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [VALUE_W-1:0]  r_cells [CAPACITY];
    logic [VALUE_W-1:0]  n_cells [CAPACITY];
    t_status             r_status, n_status;
    logic [CNT_W-1:0]    r_out_count;

    logic [CMP_W-1:0]    pos_ext, cnt_ext, idx;
    logic                do_ins, do_del;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    assign pos_ext = CMP_W'(r_pos);
    assign cnt_ext = CMP_W'(r_count);
    assign idx     = pos_ext - CMP_W'(1);

    always_comb begin
        n_status = ST_DONE;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        n_count  = r_count;
        if (r_cmd == CMD_INSERT) begin
            if ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
                n_status = ST_INVALID;
            end else if (cnt_ext == CMP_W'(CAPACITY)) begin
                n_status = ST_FULL;
            end else begin
                do_ins  = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                n_status = ST_INVALID;
            end else begin
                do_del  = 1'b1;
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        always_comb begin
            n_cells[g] = r_cells[g];
            if (do_ins) begin
                if (CMP_W'(g) == idx) begin
                    n_cells[g] = r_value;
                end else if ((g > 0) && (CMP_W'(g) > idx)) begin
                    n_cells[g] = r_cells[(g > 0) ? g - 1 : 0];
                end
            end else if (do_del) begin
                if ((g < CAPACITY - 1) && (CMP_W'(g) >= idx)) begin
                    n_cells[g] = r_cells[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd_ctl.exec) begin
                r_cells[g] <= n_cells[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd_ctl.exec) begin
            r_status    <= n_status;
            r_out_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd_ctl.exec) begin
            r_count <= n_count;
        end
    end

    assign count_wide    = {{COUNT_W{1'b0}}, r_out_count};
    assign o_entry_count = count_wide[COUNT_W-1:0];
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_ctl.exec |=> $stable(r_count))
        else $error("entry count changed without exec");

    a_invalid_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_ctl.exec && (n_status != ST_DONE)) |=> $stable(r_count))
        else $error("rejected request changed entry count");
`endif

endmodule

// ===== hdl/positional_list_engine_top.sv =====
// Channel   Handshake          Payload
// request   i_valid / o_ready  i_cmd, i_value, i_position
// result    o_valid / i_ready  o_status, o_entry_count
//
// Each request is first captured into the input registers on load; then, in exec, the
// cell row shifts and the result register loads.
// A new request is taken while the previous result waits in its register.
// Exec stalls only while that register is still full and i_ready is low.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count
);

    t_ctrl_cmd ctl_cmd;

    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (ctl_cmd)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_ctl     (ctl_cmd),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule
